[hw/rtl/pcf_pkg.sv]
`default_nettype none
package pcf_pkg;

   localparam int unsigned ReqTypeW = 3;
   localparam int unsigned PcW      = 6;

   typedef logic [PcW-1:0] pc_type;

   // request codes
   typedef enum logic [ReqTypeW-1:0] {
      REQ_STATUS = 3'd0,
      REQ_STOP   = 3'd1,
      REQ_VOLUME = 3'd2,
      REQ_REPEAT = 3'd3,
      REQ_PLAY   = 3'd4,
      REQ_FORGET = 3'd5
   } req_code_type;

   // frame constants
   localparam logic [7:0] START_BYTE   = 8'hAA;
   localparam logic [7:0] CMD_STATUS   = 8'h01;
   localparam logic [7:0] CMD_STOP     = 8'h04;
   localparam logic [7:0] CMD_VOLUME   = 8'h13;
   localparam logic [7:0] CMD_LOOPMODE = 8'h18;
   localparam logic [7:0] CMD_REPEATS  = 8'h19;
   localparam logic [7:0] CMD_PLAY     = 8'h08;
   localparam logic [7:0] LEN_ZERO     = 8'h00;
   localparam logic [7:0] LEN_ONE      = 8'h01;
   localparam logic [7:0] LEN_TWO      = 8'h02;
   localparam logic [7:0] LEN_PATH     = 8'h0B;
   localparam logic [7:0] LOOP_ON      = 8'h01;
   localparam logic [7:0] DRIVE_SD     = 8'h02;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_STAR      = 8'h2A;
   localparam logic [7:0] CH_M         = 8'h4D;
   localparam logic [7:0] CH_P         = 8'h50;
   localparam logic [7:0] CH_3         = 8'h33;
   localparam logic [3:0] ASCII_DIGIT  = 4'h3;
   localparam logic [7:0] VOLUME_MAX   = 8'd30;

   // reciprocal of ten, exact for 16-bit dividends
   localparam logic [15:0] RECIP_TEN   = 16'd52429;
   localparam int unsigned RECIP_SHIFT = 19;

   typedef enum logic [2:0] {
      OP_NEXT,
      OP_END,
      OP_DIV,
      OP_VOLCHK,
      OP_FORGET
   } op_type;

   typedef enum logic [2:0] {
      SRC_NONE,
      SRC_CONST,
      SRC_VOL,
      SRC_REP_HI,
      SRC_REP_LO,
      SRC_DIGIT,
      SRC_SUM
   } src_type;

   typedef struct packed {
      op_type     op;
      src_type    src;
      logic [7:0] konst;
   } cw_type;

   typedef struct packed {
      logic   load;
      logic   step;
      cw_type cw;
   } ctl_type;

   typedef struct packed {
      logic vol_bad;
      logic slot_free;
   } stat_type;

   // program entry points
   localparam pc_type UC_STATUS = 6'd0;
   localparam pc_type UC_STOP   = 6'd4;
   localparam pc_type UC_VOLUME = 6'd8;
   localparam pc_type UC_REPEAT = 6'd14;
   localparam pc_type UC_PLAY   = 6'd25;
   localparam pc_type UC_FORGET = 6'd45;
   localparam pc_type UC_IGNORE = 6'd46;

   function automatic cw_type mk(op_type op, src_type src, logic [7:0] k);
      cw_type c;
      c.op    = op;
      c.src   = src;
      c.konst = k;
      return c;
   endfunction

   function automatic pc_type entry(logic [ReqTypeW-1:0] t);
      pc_type p;
      case (t)
         REQ_STATUS: p = UC_STATUS;
         REQ_STOP:   p = UC_STOP;
         REQ_VOLUME: p = UC_VOLUME;
         REQ_REPEAT: p = UC_REPEAT;
         REQ_PLAY:   p = UC_PLAY;
         REQ_FORGET: p = UC_FORGET;
         default:    p = UC_IGNORE;
      endcase
      return p;
   endfunction

   // control store
   function automatic cw_type ucode(pc_type pc);
      cw_type c;
      case (pc)
         // status request
         6'd0:  c = mk(OP_NEXT,   SRC_CONST,  START_BYTE);
         6'd1:  c = mk(OP_NEXT,   SRC_CONST,  CMD_STATUS);
         6'd2:  c = mk(OP_NEXT,   SRC_CONST,  LEN_ZERO);
         6'd3:  c = mk(OP_END,    SRC_SUM,    LEN_ZERO);
         // stop
         6'd4:  c = mk(OP_NEXT,   SRC_CONST,  START_BYTE);
         6'd5:  c = mk(OP_NEXT,   SRC_CONST,  CMD_STOP);
         6'd6:  c = mk(OP_NEXT,   SRC_CONST,  LEN_ZERO);
         6'd7:  c = mk(OP_END,    SRC_SUM,    LEN_ZERO);
         // set volume
         6'd8:  c = mk(OP_VOLCHK, SRC_NONE,   LEN_ZERO);
         6'd9:  c = mk(OP_NEXT,   SRC_CONST,  START_BYTE);
         6'd10: c = mk(OP_NEXT,   SRC_CONST,  CMD_VOLUME);
         6'd11: c = mk(OP_NEXT,   SRC_CONST,  LEN_ONE);
         6'd12: c = mk(OP_NEXT,   SRC_VOL,    LEN_ZERO);
         6'd13: c = mk(OP_END,    SRC_SUM,    LEN_ZERO);
         // set repeats: loop mode frame, then count frame
         6'd14: c = mk(OP_NEXT,   SRC_CONST,  START_BYTE);
         6'd15: c = mk(OP_NEXT,   SRC_CONST,  CMD_LOOPMODE);
         6'd16: c = mk(OP_NEXT,   SRC_CONST,  LEN_ONE);
         6'd17: c = mk(OP_NEXT,   SRC_CONST,  LOOP_ON);
         6'd18: c = mk(OP_NEXT,   SRC_SUM,    LEN_ZERO);
         6'd19: c = mk(OP_NEXT,   SRC_CONST,  START_BYTE);
         6'd20: c = mk(OP_NEXT,   SRC_CONST,  CMD_REPEATS);
         6'd21: c = mk(OP_NEXT,   SRC_CONST,  LEN_TWO);
         6'd22: c = mk(OP_NEXT,   SRC_REP_HI, LEN_ZERO);
         6'd23: c = mk(OP_NEXT,   SRC_REP_LO, LEN_ZERO);
         6'd24: c = mk(OP_END,    SRC_SUM,    LEN_ZERO);
         // play file: five divide steps, then the frame
         6'd25: c = mk(OP_DIV,    SRC_NONE,   LEN_ZERO);
         6'd26: c = mk(OP_DIV,    SRC_NONE,   LEN_ZERO);
         6'd27: c = mk(OP_DIV,    SRC_NONE,   LEN_ZERO);
         6'd28: c = mk(OP_DIV,    SRC_NONE,   LEN_ZERO);
         6'd29: c = mk(OP_DIV,    SRC_NONE,   LEN_ZERO);
         6'd30: c = mk(OP_NEXT,   SRC_CONST,  START_BYTE);
         6'd31: c = mk(OP_NEXT,   SRC_CONST,  CMD_PLAY);
         6'd32: c = mk(OP_NEXT,   SRC_CONST,  LEN_PATH);
         6'd33: c = mk(OP_NEXT,   SRC_CONST,  DRIVE_SD);
         6'd34: c = mk(OP_NEXT,   SRC_CONST,  CH_SLASH);
         6'd35: c = mk(OP_NEXT,   SRC_DIGIT,  LEN_ZERO);
         6'd36: c = mk(OP_NEXT,   SRC_DIGIT,  LEN_ZERO);
         6'd37: c = mk(OP_NEXT,   SRC_DIGIT,  LEN_ZERO);
         6'd38: c = mk(OP_NEXT,   SRC_DIGIT,  LEN_ZERO);
         6'd39: c = mk(OP_NEXT,   SRC_DIGIT,  LEN_ZERO);
         6'd40: c = mk(OP_NEXT,   SRC_CONST,  CH_STAR);
         6'd41: c = mk(OP_NEXT,   SRC_CONST,  CH_M);
         6'd42: c = mk(OP_NEXT,   SRC_CONST,  CH_P);
         6'd43: c = mk(OP_NEXT,   SRC_CONST,  CH_3);
         6'd44: c = mk(OP_END,    SRC_SUM,    LEN_ZERO);
         // forget volume
         6'd45: c = mk(OP_FORGET, SRC_NONE,   LEN_ZERO);
         // unknown request
         default: c = mk(OP_END,  SRC_NONE,   LEN_ZERO);
      endcase
      return c;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/pcf_if.sv]
`default_nettype none
interface pcf_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  req_type;
   logic [7:0]  volume;
   logic [15:0] repeat_count;
   logic [15:0] file_number;

   modport source (output valid, req_type, volume, repeat_count, file_number, input ready);
   modport sink (input valid, req_type, volume, repeat_count, file_number, output ready);
   modport monitor (input valid, ready, req_type, volume, repeat_count, file_number);
endinterface

interface pcf_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tx_byte;
   logic       last_byte;

   modport source (output valid, tx_byte, last_byte, input ready);
   modport sink (input valid, tx_byte, last_byte, output ready);
   modport monitor (input valid, ready, tx_byte, last_byte);
endinterface
`default_nettype wire

[hw/rtl/pcf_seq.sv]
`default_nettype none
module pcf_seq (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [2:0]        req_type,
   output logic                   req_ready,
   input  wire pcf_pkg::stat_type stat,
   output pcf_pkg::ctl_type       ctl
);

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } state_type;

   state_type        state_ff, state_in;
   pcf_pkg::pc_type  pc_ff, pc_in;
   pcf_pkg::cw_type  cw;
   logic             load, step, emit, done;

   assign cw        = pcf_pkg::ucode(pc_ff);
   assign req_ready = (state_ff == ST_IDLE);
   assign load      = req_valid && req_ready;
   assign emit      = (cw.src != pcf_pkg::SRC_NONE);
   // an emitting step waits for room in the output register
   assign step      = (state_ff == ST_RUN) && (!emit || stat.slot_free);
   assign done      = (cw.op == pcf_pkg::OP_END) || (cw.op == pcf_pkg::OP_FORGET) ||
                      ((cw.op == pcf_pkg::OP_VOLCHK) && stat.vol_bad);

   assign ctl.load = load;
   assign ctl.step = step;
   assign ctl.cw   = cw;

   always_comb begin
      state_in = state_ff;
      pc_in    = pc_ff;
      case (state_ff)
         ST_IDLE: begin
            if (load) begin
               state_in = ST_RUN;
               pc_in    = pcf_pkg::entry(req_type);
            end
         end
         ST_RUN: begin
            if (step) begin
               if (done) begin
                  state_in = ST_IDLE;
               end else begin
                  pc_in = pc_ff + pcf_pkg::pc_type'(1);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pc_ff    <= '0;
      end else begin
         state_ff <= state_in;
         pc_ff    <= pc_in;
      end
   end

endmodule
`default_nettype wire

[hw/rtl/pcf_dpath.sv]
`default_nettype none
module pcf_dpath (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire pcf_pkg::ctl_type ctl,
   output pcf_pkg::stat_type     stat,
   input  wire logic [7:0]       volume,
   input  wire logic [15:0]      repeat_count,
   input  wire logic [15:0]      file_number,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [7:0]            tx_byte,
   output logic                  rsp_last
);

   localparam int unsigned QW = 16 - pcf_pkg::RECIP_SHIFT + 16;

   logic [7:0]       vol_ff;
   logic [15:0]      rep_ff;
   logic [15:0]      val_ff, val_in;
   logic [4:0][3:0]  dig_ff, dig_in;
   logic [7:0]       sum_ff, sum_in;
   logic [4:0]       last_vol_ff, last_vol_in;
   logic             valid_ff, valid_in;
   logic [7:0]       byte_ff, byte_in;
   logic             last_ff, last_in;

   logic [31:0]      prod;
   logic [QW-1:0]    quot;
   logic [3:0]       rem;
   logic [7:0]       sel_byte;
   logic             emit;

   assign prod = 32'(val_ff) * 32'(pcf_pkg::RECIP_TEN);
   assign quot = prod[31:pcf_pkg::RECIP_SHIFT];
   assign rem  = 4'(val_ff - ({3'b0, quot} << 3) - ({3'b0, quot} << 1));

   assign emit = ctl.step && (ctl.cw.src != pcf_pkg::SRC_NONE);

   always_comb begin
      case (ctl.cw.src)
         pcf_pkg::SRC_CONST:  sel_byte = ctl.cw.konst;
         pcf_pkg::SRC_VOL:    sel_byte = vol_ff;
         pcf_pkg::SRC_REP_HI: sel_byte = rep_ff[15:8];
         pcf_pkg::SRC_REP_LO: sel_byte = rep_ff[7:0];
         pcf_pkg::SRC_DIGIT:  sel_byte = {pcf_pkg::ASCII_DIGIT, dig_ff[0]};
         pcf_pkg::SRC_SUM:    sel_byte = sum_ff;
         default:             sel_byte = '0;
      endcase
   end

   assign stat.vol_bad   = (vol_ff == 8'd0) || (vol_ff > pcf_pkg::VOLUME_MAX) ||
                           (vol_ff == {3'b0, last_vol_ff});
   assign stat.slot_free = !valid_ff || rsp_ready;

   always_comb begin
      val_in      = val_ff;
      dig_in      = dig_ff;
      sum_in      = sum_ff;
      last_vol_in = last_vol_ff;
      valid_in    = valid_ff && !rsp_ready;
      byte_in     = byte_ff;
      last_in     = last_ff;
      if (ctl.load) begin
         val_in = file_number;
         sum_in = '0;
      end
      if (ctl.step) begin
         case (ctl.cw.op)
            pcf_pkg::OP_DIV: begin
               // remainders enter at the bottom; the leading digit ends up at index 0
               val_in = 16'(quot);
               dig_in = {dig_ff[3:0], rem};
            end
            pcf_pkg::OP_VOLCHK: begin
               if (!stat.vol_bad) last_vol_in = vol_ff[4:0];
            end
            pcf_pkg::OP_FORGET: last_vol_in = '0;
            default: ;
         endcase
      end
      if (emit) begin
         valid_in = 1'b1;
         byte_in  = sel_byte;
         last_in  = (ctl.cw.op == pcf_pkg::OP_END);
         sum_in   = (ctl.cw.src == pcf_pkg::SRC_SUM) ? 8'd0 : 8'(sum_ff + sel_byte);
         if (ctl.cw.src == pcf_pkg::SRC_DIGIT) dig_in = {4'd0, dig_ff[4:1]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_vol_ff <= '0;
         valid_ff    <= 1'b0;
         sum_ff      <= '0;
      end else begin
         last_vol_ff <= last_vol_in;
         valid_ff    <= valid_in;
         sum_ff      <= sum_in;
      end
      if (ctl.load) begin
         vol_ff <= volume;
         rep_ff <= repeat_count + 16'd1;
      end
      val_ff  <= val_in;
      dig_ff  <= dig_in;
      byte_ff <= byte_in;
      last_ff <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign tx_byte   = byte_ff;
   assign rsp_last  = last_ff;

endmodule
`default_nettype wire

[hw/rtl/player_command_framer_core.sv]
`default_nettype none
// Command framer for a serial audio player.
//
// req_chan: one command per transfer (req_type, volume, repeat_count,
//   file_number). rsp_chan: one frame byte per transfer; last_byte marks
//   the final byte a command produces. Rejected or unchanged volume, forget
//   volume and unknown codes give no rsp transfer at all.
// Control is a small program in a constant control store; the sequencer
//   steps one control word per cycle, an emitting word waiting for room;
//   the datapath mixes in the payload, keeps the running checksum and turns
//   the file number into digits.
// Order: the request is registered into the sequencer, each frame byte into
//   the output register; set volume first runs its range check, play file
//   first runs five divide-by-ten steps. A command holds the block until its
//   program ends; req_chan.ready is high only between commands; one command
//   is worked on at a time.
// Stall: a byte waits in the output register while rsp_chan.ready is low
//   and the program holds on its next byte; the final byte may still wait
//   while the next command is taken.
// Reset: synchronous; clears the sequencer, the output valid, the checksum
//   and the remembered volume (no volume sent).
module player_command_framer_core (
   input  wire logic  clock,
   input  wire logic  reset,
   pcf_req_if.sink    req_chan,
   pcf_rsp_if.source  rsp_chan
);

   pcf_pkg::ctl_type  ctl;
   pcf_pkg::stat_type stat;

   // step counter and control store
   pcf_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_type  (req_chan.req_type),
      .req_ready (req_chan.ready),
      .stat      (stat),
      .ctl       (ctl)
   );

   // payload, checksum, digit divider, remembered volume, output register
   pcf_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .stat         (stat),
      .volume       (req_chan.volume),
      .repeat_count (req_chan.repeat_count),
      .file_number  (req_chan.file_number),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .tx_byte      (rsp_chan.tx_byte),
      .rsp_last     (rsp_chan.last_byte)
   );

endmodule
`default_nettype wire

[hw/rtl/pcf_checker.sv]
`default_nettype none
module pcf_checker (
   input  wire logic   clock,
   input  wire logic   reset,
   pcf_req_if.sink     req_chan,
   pcf_rsp_if.source   rsp_chan
);

   // a stalled byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=>
         rsp_chan.valid && $stable(rsp_chan.tx_byte) && $stable(rsp_chan.last_byte))
      else $error("rsp byte changed while stalled");

   // nothing to send right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("rsp valid after reset");

   // every command occupies the block for at least one step
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("req taken on back-to-back cycles");

   // while a non-final byte is pending, the command is still running
   a_mid_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.last_byte |-> !req_chan.ready)
      else $error("req ready in the middle of a command");

endmodule

bind player_command_framer_core pcf_checker u_pcf_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
`default_nettype wire
